>>> rtl/tfbc_pkg.sv
// ---------------------------------------------------------------------------
// tfbc_pkg
// Shared types, codes and helpers of the tagged four-byte frame codec:
// item layouts, tag codes and the byte encoder used on the send path.
// ---------------------------------------------------------------------------
package tfbc_pkg;

  // frame geometry
  localparam int unsigned TagW     = 2;
  localparam int unsigned PayW     = 6;
  localparam int unsigned ByteW    = TagW + PayW;
  localparam int unsigned NumSlots = 4;
  localparam int unsigned SlotW    = $clog2(NumSlots);

  // position tags, also the slot index of a byte on the send path
  localparam logic [SlotW-1:0] SlotAddr   = 2'd0;
  localparam logic [SlotW-1:0] SlotAddrLo = 2'd1;
  localparam logic [SlotW-1:0] SlotDataHi = 2'd2;
  localparam logic [SlotW-1:0] SlotDataLo = 2'd3;
  localparam logic [SlotW-1:0] SlotLast   = SlotDataLo;

  // item codes
  typedef enum logic {
    ACT_RX = 1'b0,
    ACT_TX = 1'b1
  } action_e;

  typedef enum logic {
    KIND_RX = 1'b0,
    KIND_TX = 1'b1
  } kind_e;

  // input item
  typedef struct packed {
    logic        action;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_address;
    logic [15:0] tx_data;
  } in_item_t;

  // result item
  typedef struct packed {
    logic        kind;
    logic        frame_status;
    logic [7:0]  rx_address;
    logic [15:0] rx_data;
    logic [7:0]  tx_byte;
    logic        last;
  } out_item_t;

  // four received bytes, index is arrival order
  typedef logic [NumSlots-1:0][ByteW-1:0] frame_t;

  // decoder result
  typedef struct packed {
    logic        ok;
    logic [7:0]  address;
    logic [15:0] data;
  } rx_frame_t;

  // tagged byte for one slot of a send
  function automatic logic [ByteW-1:0] tx_encode(input logic [7:0]       addr,
                                                 input logic [15:0]      data,
                                                 input logic [SlotW-1:0] slot);
    logic [ByteW-1:0] b;
    case (slot)
      SlotAddr:   b = {SlotAddr, addr[7:2]};
      SlotAddrLo: b = {SlotAddrLo, addr[1:0], data[15:12]};
      SlotDataHi: b = {SlotDataHi, data[11:8], data[7:6]};
      default:    b = {SlotDataLo, data[5:0]};
    endcase
    return b;
  endfunction

endpackage

>>> rtl/tfbc_if.sv
// ---------------------------------------------------------------------------
// tfbc_in_if / tfbc_out_if
// Valid/ready channels of the codec, one for input items and one for
// result items.
// ---------------------------------------------------------------------------
interface tfbc_in_if import tfbc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tfbc_out_if import tfbc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/tagged_four_byte_frame_codec_unit.sv
// ---------------------------------------------------------------------------
// tagged_four_byte_frame_codec_unit
// Frame codec for an 8-bit address and 16-bit word in four tagged bytes.
// Receive bytes are grouped in fours and decoded; a send becomes four bytes.
//
//   channel | dir | handshake       | item
//   --------+-----+-----------------+-------------------------------------
//   in_i    | in  | valid / ready   | action, rx_byte, tx_address, tx_data
//   out_o   | out | valid / ready   | kind, frame_status, rx_address,
//           |     |                 | rx_data, tx_byte, last
//
// a receive item gives one result in the cycle after it is accepted
// a send item gives four bytes: the single result register emits one byte
// per cycle while out_o.ready allows, and the input is held off until the fourth byte is loaded
// reset clears the byte position, the held address and data, and all valids
// out_o.ready low holds the result in place and stalls the input
// ---------------------------------------------------------------------------
module tagged_four_byte_frame_codec_unit import tfbc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  tfbc_in_if.sink           in_i,
  tfbc_out_if.source        out_o
);

  localparam int unsigned StoreN = NumSlots - 1;

  logic                  in_fire;
  logic                  out_free;

  logic [SlotW-1:0]      byte_pos_q, byte_pos_d;
  logic [ByteW-1:0]      frame_q [StoreN];
  logic [ByteW-1:0]      frame_d [StoreN];
  logic [7:0]            held_addr_q, held_addr_d;
  logic [15:0]           held_data_q, held_data_d;

  logic                  tx_busy_q, tx_busy_d;
  logic [SlotW-1:0]      tx_slot_q, tx_slot_d;
  logic [7:0]            tx_addr_q, tx_addr_d;
  logic [15:0]           tx_data_q, tx_data_d;

  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  frame_t                frame_in;
  rx_frame_t             rx_frame;

  // handshake
  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = out_free && !tx_busy_q;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // group under check: three stored bytes plus the arriving one
  always_comb begin
    for (int k = 0; k < StoreN; k++) begin
      frame_in[k] = frame_q[k];
    end
    frame_in[StoreN] = in_i.data.rx_byte;
  end

  tfbc_rx_decode u_rx_decode (
    .frame_i  (frame_in),
    .result_o (rx_frame)
  );

  // next-state logic
  always_comb begin
    byte_pos_d  = byte_pos_q;
    frame_d     = frame_q;
    held_addr_d = held_addr_q;
    held_data_d = held_data_q;
    tx_busy_d   = tx_busy_q;
    tx_slot_d   = tx_slot_q;
    tx_addr_d   = tx_addr_q;
    tx_data_d   = tx_data_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (in_fire) begin
      out_valid_d = 1'b1;
      if (in_i.data.action == ACT_RX) begin
        out_d.frame_status = 1'b0;
        if (byte_pos_q != SlotLast) begin
          // collect byte of the group
          frame_d[byte_pos_q] = in_i.data.rx_byte;
          byte_pos_d          = byte_pos_q + SlotW'(1);
        end else begin
          // fourth byte: check the group and latch on success
          byte_pos_d = SlotAddr;
          if (rx_frame.ok) begin
            held_addr_d        = rx_frame.address;
            held_data_d        = rx_frame.data;
            out_d.frame_status = 1'b1;
          end
        end
        out_d.kind       = KIND_RX;
        out_d.rx_address = held_addr_d;
        out_d.rx_data    = held_data_d;
        out_d.tx_byte    = '0;
        out_d.last       = 1'b1;
      end else begin
        // send: first byte now, the rest from the sequencer
        tx_busy_d          = 1'b1;
        tx_slot_d          = SlotAddrLo;
        tx_addr_d          = in_i.data.tx_address;
        tx_data_d          = in_i.data.tx_data;
        out_d.kind         = KIND_TX;
        out_d.frame_status = 1'b0;
        out_d.rx_address   = held_addr_q;
        out_d.rx_data      = held_data_q;
        out_d.tx_byte      = tx_encode(in_i.data.tx_address, in_i.data.tx_data,
                                       SlotAddr);
        out_d.last         = 1'b0;
      end
    end else if (tx_busy_q && out_free) begin
      // remaining send bytes, one per cycle while the output is free
      out_valid_d        = 1'b1;
      out_d.kind         = KIND_TX;
      out_d.frame_status = 1'b0;
      out_d.rx_address   = held_addr_q;
      out_d.rx_data      = held_data_q;
      out_d.tx_byte      = tx_encode(tx_addr_q, tx_data_q, tx_slot_q);
      out_d.last         = (tx_slot_q == SlotLast);
      tx_slot_d          = tx_slot_q + SlotW'(1);
      if (tx_slot_q == SlotLast) begin
        tx_busy_d = 1'b0;
      end
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q  <= SlotAddr;
      held_addr_q <= '0;
      held_data_q <= '0;
      tx_busy_q   <= 1'b0;
      tx_slot_q   <= SlotAddr;
      out_valid_q <= 1'b0;
    end else begin
      byte_pos_q  <= byte_pos_d;
      held_addr_q <= held_addr_d;
      held_data_q <= held_data_d;
      tx_busy_q   <= tx_busy_d;
      tx_slot_q   <= tx_slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    frame_q   <= frame_d;
    tx_addr_q <= tx_addr_d;
    tx_data_q <= tx_data_d;
    out_q     <= out_d;
  end

endmodule

>>> rtl/tfbc_rx_decode.sv
// ---------------------------------------------------------------------------
// tfbc_rx_decode
// Checks that a group of four received bytes carries every tag once and
// rebuilds the address and data word from the payloads.
// ---------------------------------------------------------------------------
module tfbc_rx_decode import tfbc_pkg::*; (
  input  frame_t    frame_i,
  output rx_frame_t result_o
);

  logic [NumSlots-1:0]             seen;
  logic [NumSlots-1:0][ByteW-1:0]  by_tag;

  // sort bytes by tag and note which tags turned up
  always_comb begin
    seen   = '0;
    by_tag = '0;
    for (int k = 0; k < NumSlots; k++) begin
      seen[frame_i[k][ByteW-1:PayW]]   = 1'b1;
      by_tag[frame_i[k][ByteW-1:PayW]] = frame_i[k];
    end
  end

  // reassemble fields
  always_comb begin
    result_o.ok      = &seen;
    result_o.address = {by_tag[SlotAddr][5:0], by_tag[SlotAddrLo][5:4]};
    result_o.data    = {by_tag[SlotAddrLo][3:0], by_tag[SlotDataHi][5:0],
                        by_tag[SlotDataLo][5:0]};
  end

endmodule

>>> rtl/tfbc_checker.sv
// ---------------------------------------------------------------------------
// tfbc_checker
// Port-level checks of the frame codec, bound to the top level.
// ---------------------------------------------------------------------------
module tfbc_checker import tfbc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input in_item_t  in_data_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_i;

  // a result is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed or dropped while stalled");

  // a receive item gives one final status result next cycle
  a_rx_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.action == ACT_RX |=>
      out_valid_i && out_data_i.kind == KIND_RX && out_data_i.last &&
      out_data_i.tx_byte == '0)
    else $error("receive item did not give a single status result");

  // a send item opens with a non-final byte of tag zero
  a_tx_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.action == ACT_TX |=>
      out_valid_i && out_data_i.kind == KIND_TX && !out_data_i.last &&
      out_data_i.tx_byte[ByteW-1:PayW] == SlotAddr)
    else $error("send item did not start with the tag zero byte");

  // no new item while a send still has bytes to come
  a_tx_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.kind == KIND_TX && !out_data_i.last |-> !in_ready_i)
    else $error("input taken in the middle of a send");

  // frame status is only reported on receive results
  a_status_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.frame_status |-> out_data_i.kind == KIND_RX)
    else $error("frame status set on a transmit byte");

endmodule

bind tagged_four_byte_frame_codec_unit tfbc_checker u_tfbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_data_i   (in_i.data),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

>>> sim/tagged_four_byte_frame_codec_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tagged_four_byte_frame_codec_unit_tb
// Self-checking bench for the tagged four-byte frame codec. A queue of link
// items feeds a clocked driver; a clocked monitor predicts the results of
// every accepted item and compares each result field by field. Stimulus is a
// directed set followed by mostly well-formed random frames mixed with
// sends, broken frames and stray bytes, under random idling and one long
// receiver hold-off.
// ---------------------------------------------------------------------------
module tagged_four_byte_frame_codec_unit_tb;
  import tfbc_pkg::*;

  localparam int HoldOffCycles = 80;
  localparam int IdlePercent   = 21;
  localparam int SettleCycles  = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tfbc_in_if  in_ch ();
  tfbc_out_if out_ch ();

  tagged_four_byte_frame_codec_unit uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // clock
  always #5 clk = ~clk;

  // items still to be offered and results still owed by the block
  in_item_t  link_items [$];
  out_item_t awaited_outputs [$];

  int  items_queued    = 0;
  int  rx_bytes_queued = 0;
  int  mismatches      = 0;
  int  hold_left       = 0;
  bit  idle_on         = 1'b0;
  bit  hold_off_req    = 1'b0;
  bit  drained         = 1'b0;
  logic in_taken       = 1'b0;

  // predictor state: receive group and latched frame
  logic [1:0] rx_slot = SlotAddr;
  logic [7:0] rx_group [4];
  logic [7:0] latched_addr = 8'h00;
  logic [15:0] latched_data = 16'h0000;

  // tagged link byte for one position of a frame
  function automatic logic [7:0] link_byte(input logic [7:0] a, input logic [15:0] d,
                                           input logic [1:0] tag);
    logic [5:0] pay;
    case (tag)
      SlotAddr:   pay = a[7:2];
      SlotAddrLo: pay = {a[1:0], d[15:12]};
      SlotDataHi: pay = d[11:6];
      default:    pay = d[5:0];
    endcase
    return {tag, pay};
  endfunction

  // expected results of one accepted item
  task automatic predict_codec_outputs(input in_item_t it);
    out_item_t  r;
    logic [3:0] seen;
    logic [7:0] by_tag [4];
    logic       status;
    status = 1'b0;
    if (it.action == ACT_RX) begin
      rx_group[rx_slot] = it.rx_byte;
      if (rx_slot != SlotLast) begin
        rx_slot = rx_slot + 2'd1;
      end else begin
        // group complete: accept only with every tag present once
        rx_slot = SlotAddr;
        seen = 4'b0000;
        for (int k = 0; k < 4; k++) begin
          seen[rx_group[k][7:6]] = 1'b1;
          by_tag[rx_group[k][7:6]] = rx_group[k];
        end
        if (&seen) begin
          latched_addr = {by_tag[SlotAddr][5:0], by_tag[SlotAddrLo][5:4]};
          latched_data = {by_tag[SlotAddrLo][3:0], by_tag[SlotDataHi][5:0],
                          by_tag[SlotDataLo][5:0]};
          status = 1'b1;
        end
      end
      r.kind         = KIND_RX;
      r.frame_status = status;
      r.rx_address   = latched_addr;
      r.rx_data      = latched_data;
      r.tx_byte      = 8'h00;
      r.last         = 1'b1;
      awaited_outputs.push_back(r);
    end else begin
      // send: four tagged bytes in tag order, last flagged
      for (int k = 0; k < 4; k++) begin
        r.kind         = KIND_TX;
        r.frame_status = 1'b0;
        r.rx_address   = latched_addr;
        r.rx_data      = latched_data;
        r.tx_byte      = link_byte(it.tx_address, it.tx_data, k[1:0]);
        r.last         = (k[1:0] == SlotLast);
        awaited_outputs.push_back(r);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // driver: next item at the falling edge once the previous one has gone
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (link_items.size() != 0 && !(idle_on && $urandom_range(0, 99) < IdlePercent)) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= link_items.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left    = HoldOffCycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(idle_on && $urandom_range(0, 99) < IdlePercent);
    end
  end

  // monitor: predict on input handshakes, check on output handshakes
  always @(posedge clk) begin : monitor
    out_item_t want;
    in_taken <= in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        predict_codec_outputs(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_outputs.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_ch.data);
          mismatches++;
        end else begin
          want = awaited_outputs.pop_front();
          check_field("kind", 16'(want.kind), 16'(out_ch.data.kind));
          check_field("frame_status", 16'(want.frame_status),
                      16'(out_ch.data.frame_status));
          check_field("rx_address", 16'(want.rx_address), 16'(out_ch.data.rx_address));
          check_field("rx_data", want.rx_data, out_ch.data.rx_data);
          check_field("tx_byte", 16'(want.tx_byte), 16'(out_ch.data.tx_byte));
          check_field("last", 16'(want.last), 16'(out_ch.data.last));
        end
      end
    end
    drained = (link_items.size() == 0) && !(in_ch.valid && !in_ch.ready) &&
              (awaited_outputs.size() == 0);
  end

  task automatic queue_item(input logic act, input logic [7:0] b, input logic [7:0] a,
                            input logic [15:0] d);
    in_item_t it;
    it.action     = act;
    it.rx_byte    = b;
    it.tx_address = a;
    it.tx_data    = d;
    link_items.push_back(it);
    items_queued++;
    if (act == ACT_RX)
      rx_bytes_queued++;
  endtask

  // unused fields carry random values
  task automatic queue_rx(input logic [7:0] b);
    queue_item(ACT_RX, b, 8'($urandom), 16'($urandom));
  endtask

  task automatic queue_tx(input logic [7:0] a, input logic [15:0] d);
    queue_item(ACT_TX, 8'($urandom), a, d);
  endtask

  // four received bytes of one frame, optionally reordered, broken or mixed with sends
  task automatic queue_frame(input logic [7:0] a, input logic [15:0] d, input bit shuffle,
                             input bit broken, input bit mix_sends);
    logic [7:0] bytes [4];
    logic [7:0] t;
    int i;
    int j;
    for (int k = 0; k < 4; k++)
      bytes[k] = link_byte(a, d, k[1:0]);
    if (shuffle) begin
      for (i = 3; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = bytes[i];
        bytes[i] = bytes[j];
        bytes[j] = t;
      end
    end
    // duplicate one tag so another goes missing
    if (broken) begin
      i = $urandom_range(0, 3);
      j = (i + $urandom_range(1, 3)) % 4;
      bytes[i][7:6] = bytes[j][7:6];
    end
    for (int k = 0; k < 4; k++) begin
      if (mix_sends && $urandom_range(0, 9) == 0)
        queue_tx(8'($urandom), 16'($urandom));
      queue_rx(bytes[k]);
    end
  endtask

  // mostly well-formed frames, some sends, broken frames and stray bytes
  task automatic queue_random_items(input int count);
    int stop_at;
    int r;
    stop_at = items_queued + count;
    while (items_queued < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 20)
        queue_tx(8'($urandom), 16'($urandom));
      else if (rx_bytes_queued % 4 != 0)
        queue_rx(8'($urandom));
      else if (r < 75)
        queue_frame(8'($urandom), 16'($urandom), 1'b1, 1'b0, 1'b1);
      else if (r < 90)
        queue_frame(8'($urandom), 16'($urandom), 1'b1, 1'b1, 1'b1);
      else
        queue_rx(8'($urandom));
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (!drained);
  endtask

  // stimulus and end of run
  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: send extremes, good frames in and out of order, rejects
    queue_tx(8'h00, 16'h0000);
    queue_tx(8'hFF, 16'hFFFF);
    queue_tx(8'hA5, 16'h5AC3);
    queue_frame(8'hFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    queue_frame(8'h5A, 16'hA53C, 1'b1, 1'b0, 1'b0);
    queue_frame(8'h3C, 16'h0FF0, 1'b1, 1'b1, 1'b0);
    queue_rx(8'h00);
    queue_rx(8'hFF);
    queue_rx(8'h00);
    queue_rx(8'hFF);
    // a send in the middle of a group leaves it intact
    queue_rx(link_byte(8'h81, 16'h8001, SlotAddr));
    queue_rx(link_byte(8'h81, 16'h8001, SlotAddrLo));
    queue_tx(8'h00, 16'hFFFF);
    queue_rx(link_byte(8'h81, 16'h8001, SlotDataHi));
    queue_rx(link_byte(8'h81, 16'h8001, SlotDataLo));
    wait_drained();

    // random with idling and a long receiver hold-off
    idle_on      = 1'b1;
    hold_off_req = 1'b1;
    queue_random_items(90);
    wait_drained();

    // random with no idling at all
    idle_on = 1'b0;
    queue_random_items(55);
    wait_drained();

    idle_on = 1'b1;
    queue_random_items(55);
    wait_drained();

    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // timeout
  initial begin
    #(2_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
